>>> hdl/ddt_pkg.sv
// ----------------------------------------------------------------------------
// ddt_pkg: shared constants for the decimal digit trie prefix table
// Status and action codes, defaults and the radix shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ddt_pkg;
   localparam int NodeCountDefault  = 1024;
   localparam int MaxDigitsDefault  = 20;
   localparam int ValueWidthDefault = 32;
   localparam int Radix             = 10;
   localparam int CountWidth        = 4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic [1:0] ACT_FIND = 2'd0;
   localparam logic [1:0] ACT_ADD  = 2'd1;
   localparam logic [1:0] ACT_DEL  = 2'd2;

   localparam logic [3:0] DIGIT_MAX = 4'(Radix - 1);
endpackage
`default_nettype wire

>>> hdl/decimal_digit_trie_prefix_table_core.sv
// ----------------------------------------------------------------------------
// decimal_digit_trie_prefix_table_core: radix-10 trie with prefix lookup
// Buffers a decimal key one digit per request, then runs find, add or
// delete on the node memory and returns one status and value.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_action req_digit req_last_digit     start high, busy low
//            req_value
//  response  rsp_status rsp_value_res                rsp_valid, one cycle
//
// A digit without last_digit is taken while the core is idle. A key is
// walked digit by digit for find, add and delete; add also creates nodes
// and delete also prunes them, and every step of the walk is a read of
// the node memory and an evaluation of the row. Bad keys respond from idle.
// After reset the root row is cleared while busy is high.
// The receiver cannot stall; busy is high from the last digit until the
// response.
`default_nettype none
module decimal_digit_trie_prefix_table_core #(
   parameter int NODE_COUNT  = ddt_pkg::NodeCountDefault,
   parameter int MAX_DIGITS  = ddt_pkg::MaxDigitsDefault,
   parameter int VALUE_WIDTH = ddt_pkg::ValueWidthDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [1:0]             req_action,
   input  wire logic [3:0]             req_digit,
   input  wire logic                   req_last_digit,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   output logic                        rsp_valid,
   output logic      [1:0]             rsp_status,
   output logic      [VALUE_WIDTH-1:0] rsp_value_res
);
   localparam int AW  = $clog2(NODE_COUNT);
   localparam int LW  = $clog2(MAX_DIGITS + 1);
   localparam int KW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CW  = ddt_pkg::CountWidth;
   localparam int RX  = ddt_pkg::Radix;
   // Row layout, low to high: digit, parent, payload, stored flag, count,
   // child links.
   localparam int O_DIG = 0;
   localparam int O_PAR = 4;
   localparam int O_PAY = O_PAR + AW;
   localparam int O_VAL = O_PAY + VALUE_WIDTH;
   localparam int O_CNT = O_VAL + 1;
   localparam int O_CH  = O_CNT + CW;
   localparam int RW    = O_CH + RX * AW;

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_EV   = 4'd3;
   localparam logic [3:0] S_AL1  = 4'd4;
   localparam logic [3:0] S_AL2  = 4'd5;
   localparam logic [3:0] S_PRD  = 4'd6;
   localparam logic [3:0] S_PEV  = 4'd7;

   logic [3:0]             state_ff, state_in;
   logic [3:0]             key_ff [MAX_DIGITS];
   logic [LW-1:0]          len_ff, len_in;
   logic                   bad_ff, bad_in;
   logic [LW-1:0]          idx_ff, idx_in;
   logic [1:0]             act_ff, act_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [AW-1:0]          cur_ff, cur_in;
   logic [AW-1:0]          new_ff, new_in;
   logic [AW-1:0]          fr_node_ff, fr_node_in;
   logic [AW-1:0]          fr_par_ff, fr_par_in;
   logic [3:0]             fr_dig_ff, fr_dig_in;
   logic [VALUE_WIDTH-1:0] res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [RW-1:0] row;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [RW-1:0] wr_data;
   logic          fl_pop, fl_push, fl_empty;
   logic [AW-1:0] fl_top;

   logic          accept, key_store, bad_now;
   logic [LW-1:0] len_now;
   logic [3:0]    kdig;
   logic [AW-1:0] child;
   logic          at_end, row_valid;
   logic [CW-1:0] row_cnt;

   ddt_node_mem #(.DEPTH(NODE_COUNT), .WIDTH(RW)) u_node_mem (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(row),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   ddt_free_list #(.DEPTH(NODE_COUNT)) u_free_list (
      .clock    (clock),
      .reset    (reset),
      .pop      (fl_pop),
      .push     (fl_push),
      .push_node(fr_node_ff),
      .top_node (fl_top),
      .empty    (fl_empty)
   );

   assign accept    = start && !busy;
   assign key_store = len_ff < LW'(MAX_DIGITS);
   assign bad_now   = bad_ff || (req_digit > ddt_pkg::DIGIT_MAX) || !key_store;
   assign len_now   = key_store ? len_ff + LW'(1) : len_ff;

   assign kdig      = key_ff[idx_ff[KW-1:0]];
   assign child     = row[O_CH + 32'(kdig) * AW +: AW];
   assign at_end    = idx_ff == len_ff;
   assign row_valid = row[O_VAL];
   assign row_cnt   = row[O_CNT +: CW];

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      bad_in        = bad_ff;
      idx_in        = idx_ff;
      act_in        = act_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      new_in        = new_ff;
      fr_node_in    = fr_node_ff;
      fr_par_in     = fr_par_ff;
      fr_dig_in     = fr_dig_ff;
      res_in        = res_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = row;
      fl_pop        = 1'b0;
      fl_push       = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '0;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               len_in = len_now;
               bad_in = bad_now;
               if (req_last_digit) begin
                  len_in = '0;
                  bad_in = 1'b0;
                  idx_in = '0;
                  cur_in = '0;
                  act_in = req_action;
                  val_in = req_value;
                  res_in = '0;
                  if (bad_now || (req_action != ddt_pkg::ACT_FIND &&
                                  req_action != ddt_pkg::ACT_ADD &&
                                  req_action != ddt_pkg::ACT_DEL)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ddt_pkg::ST_BAD;
                     rsp_value_in  = '0;
                  end else begin
                     len_in   = len_now;
                     state_in = S_RD;
                  end
               end
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_EV;
         end
         S_EV: begin
            rsp_value_in = '0;
            case (act_ff)
               ddt_pkg::ACT_FIND: begin
                  if (cur_ff != '0 && row_valid) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ddt_pkg::ST_OK;
                     rsp_value_in  = row[O_PAY +: VALUE_WIDTH];
                  end else if (at_end || child == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ddt_pkg::ST_MISS;
                  end
               end
               ddt_pkg::ACT_ADD: begin
                  if (at_end) begin
                     rsp_valid_in = 1'b1;
                     if (row_valid) begin
                        rsp_status_in = ddt_pkg::ST_MISS;
                     end else begin
                        rsp_status_in                = ddt_pkg::ST_OK;
                        wr_en                        = 1'b1;
                        wr_data[O_VAL]               = 1'b1;
                        wr_data[O_PAY +: VALUE_WIDTH] = val_ff;
                     end
                  end else if (child == '0) begin
                     if (fl_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ddt_pkg::ST_FULL;
                     end else begin
                        new_in = fl_top;
                     end
                  end
               end
               default: begin
                  if (at_end) begin
                     rsp_status_in = ddt_pkg::ST_MISS;
                     if (!row_valid) begin
                        rsp_valid_in = 1'b1;
                     end else if (row_cnt != '0) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = ddt_pkg::ST_OK;
                        rsp_value_in   = row[O_PAY +: VALUE_WIDTH];
                        wr_en          = 1'b1;
                        wr_data[O_VAL] = 1'b0;
                     end else begin
                        res_in     = row[O_PAY +: VALUE_WIDTH];
                        fr_node_in = cur_ff;
                        fr_par_in  = row[O_PAR +: AW];
                        fr_dig_in  = row[O_DIG +: 4];
                     end
                  end else if (child == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ddt_pkg::ST_MISS;
                  end
               end
            endcase
            if (rsp_valid_in) begin
               state_in = S_IDLE;
            end else if (act_ff == ddt_pkg::ACT_DEL && at_end) begin
               state_in = S_PRD;
            end else if (act_ff == ddt_pkg::ACT_ADD && child == '0) begin
               state_in = S_AL1;
            end else begin
               cur_in   = child;
               idx_in   = idx_ff + LW'(1);
               state_in = S_RD;
            end
         end
         S_AL1: begin
            // Link the new node under the current one.
            wr_en                            = 1'b1;
            wr_data[O_CH + 32'(kdig) * AW +: AW] = new_ff;
            wr_data[O_CNT +: CW]             = row_cnt + CW'(1);
            state_in                         = S_AL2;
         end
         S_AL2: begin
            wr_en                 = 1'b1;
            wr_addr               = new_ff;
            wr_data               = '0;
            wr_data[O_PAR +: AW]  = cur_ff;
            wr_data[O_DIG +: 4]   = kdig;
            fl_pop                = 1'b1;
            cur_in                = new_ff;
            idx_in                = idx_ff + LW'(1);
            state_in              = S_RD;
         end
         S_PRD: begin
            rd_en    = 1'b1;
            rd_addr  = fr_par_ff;
            state_in = S_PEV;
         end
         S_PEV: begin
            // Unlink the freed node from its parent and return it to the stack.
            wr_en                                   = 1'b1;
            wr_addr                                 = fr_par_ff;
            wr_data[O_CH + 32'(fr_dig_ff) * AW +: AW] = '0;
            wr_data[O_CNT +: CW]                    = row_cnt - CW'(1);
            fl_push                                 = 1'b1;
            if (fr_par_ff != '0 && !row_valid && row_cnt == CW'(1)) begin
               fr_node_in = fr_par_ff;
               fr_par_in  = row[O_PAR +: AW];
               fr_dig_in  = row[O_DIG +: 4];
               state_in   = S_PRD;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ddt_pkg::ST_OK;
               rsp_value_in  = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The key buffer starts empty again once the response is out.
      if (rsp_valid_in) begin
         len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         len_ff       <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && accept && key_store) begin
         key_ff[len_ff[KW-1:0]] <= (req_digit > ddt_pkg::DIGIT_MAX) ? 4'd0 : req_digit;
      end
      idx_ff        <= idx_in;
      act_ff        <= act_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      new_ff        <= new_in;
      fr_node_ff    <= fr_node_in;
      fr_par_ff     <= fr_par_in;
      fr_dig_ff     <= fr_dig_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_res = rsp_value_ff;
endmodule
`default_nettype wire

>>> hdl/ddt_node_mem.sv
// ----------------------------------------------------------------------------
// ddt_node_mem: node record memory
// One row per node holding its child links, child count, stored flag,
// payload, parent link and digit. One write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ddt_node_mem #(
   parameter int DEPTH = ddt_pkg::NodeCountDefault,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> hdl/ddt_free_list.sv
// ----------------------------------------------------------------------------
// ddt_free_list: free node stack
// Stack of free node numbers with its fill count. Entries at or above the
// highest fill ever reached were never written and read as their index plus
// one, which is the order after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module ddt_free_list #(
   parameter int DEPTH = ddt_pkg::NodeCountDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     pop,
   input  wire logic                     push,
   input  wire logic [$clog2(DEPTH)-1:0] push_node,
   output logic      [$clog2(DEPTH)-1:0] top_node,
   output logic                          empty
);
   localparam int AW = $clog2(DEPTH);

   logic [AW-1:0] mem [DEPTH];
   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] high_ff, high_in;
   logic [AW-1:0] q_ff;
   logic [AW-1:0] base_ff;
   logic          written_ff;

   always_comb begin
      count_in = count_ff;
      high_in  = high_ff;
      if (pop) begin
         count_in = count_ff + AW'(1);
         if (count_in > high_ff) begin
            high_in = count_in;
         end
      end else if (push) begin
         count_in = count_ff - AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         high_ff  <= '0;
      end else begin
         count_ff <= count_in;
         high_ff  <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[count_ff - AW'(1)] <= push_node;
      end
      q_ff       <= mem[count_ff];
      base_ff    <= count_ff + AW'(1);
      written_ff <= count_ff < high_ff;
   end

   assign top_node = written_ff ? q_ff : base_ff;
   assign empty    = count_ff == AW'(DEPTH - 1);
endmodule
`default_nettype wire

>>> hdl/ddt_checker.sv
// ----------------------------------------------------------------------------
// ddt_checker: port-level checks for the trie core
// Watches the request and response ports over time.
// ----------------------------------------------------------------------------
`default_nettype none
module ddt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       req_last_digit,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_nonzero
);
   // A last digit either starts a walk or is answered at once.
   a_last_reacts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_digit |=> busy || rsp_valid)
      else $error("last digit neither started work nor responded");

   // Work only begins on a last digit.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_last_digit))
      else $error("busy rose without a last digit");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ddt_pkg::ST_OK |-> !rsp_nonzero)
      else $error("failed request returned a value");
endmodule

bind decimal_digit_trie_prefix_table_core ddt_checker u_ddt_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_last_digit(req_last_digit),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_nonzero   (|rsp_value_res)
);
`default_nettype wire
